/* rtl/otcs_pkg.sv */
// ----------------------------------------------------------------------------
// otcs_pkg
// Shared widths, command codes, register indexes and tuning constants for the
// oscillator tuning code stepper.
// ----------------------------------------------------------------------------
package otcs_pkg;

  localparam int CODE_MAX_DEFAULT = 31;

  // Fixed widths of the command, result and configuration fields
  localparam int MODE_W  = 3;
  localparam int STEP_W  = 4;
  localparam int FIELD_W = 5;
  localparam int CFG_IDX_W = 3;

  // Command codes
  localparam logic [MODE_W-1:0] MODE_LOAD        = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FINE_UP     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FINE_DOWN   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MID_UP      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MID_DOWN    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SWEEP_START = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SWEEP_STEP  = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COARSE_FIRST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COARSE_LAST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MID_FIRST    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MID_LAST     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FINE_FIRST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FINE_LAST    = 3'd5;

  // Tuning constants
  localparam int MID_PER_CHANNEL = 6;
  localparam int FINE_OVERLAP    = 9;
  localparam int MID_OVERLAP     = 13;
  localparam int MID_RX_TX       = 1;

endpackage

/* rtl/otcs_cmd_if.sv */
// ----------------------------------------------------------------------------
// otcs_cmd_if
// Command channel: valid/ready handshake with the command fields.
// ----------------------------------------------------------------------------
interface otcs_cmd_if;

  logic                          valid;
  logic                          ready;
  logic [otcs_pkg::MODE_W-1:0]   mode;
  logic [otcs_pkg::STEP_W-1:0]   step_amount;
  logic [otcs_pkg::FIELD_W-1:0]  new_coarse;
  logic [otcs_pkg::FIELD_W-1:0]  new_mid;
  logic [otcs_pkg::FIELD_W-1:0]  new_fine;

  modport source (
    output valid, mode, step_amount, new_coarse, new_mid, new_fine,
    input  ready
  );

  modport sink (
    input  valid, mode, step_amount, new_coarse, new_mid, new_fine,
    output ready
  );

endinterface

/* rtl/otcs_res_if.sv */
// ----------------------------------------------------------------------------
// otcs_res_if
// Result channel: valid/ready handshake with the tuning code and status flags.
// ----------------------------------------------------------------------------
interface otcs_res_if;

  logic                          valid;
  logic                          ready;
  logic [otcs_pkg::FIELD_W-1:0]  coarse_code;
  logic [otcs_pkg::FIELD_W-1:0]  mid_code;
  logic [otcs_pkg::FIELD_W-1:0]  fine_code;
  logic                          sweep_done;
  logic                          ranges_valid;
  logic                          range_error;

  modport source (
    output valid, coarse_code, mid_code, fine_code, sweep_done, ranges_valid,
           range_error,
    input  ready
  );

  modport sink (
    input  valid, coarse_code, mid_code, fine_code, sweep_done, ranges_valid,
           range_error,
    output ready
  );

endinterface

/* rtl/oscillator_tuning_code_stepper_top.sv */
// ----------------------------------------------------------------------------
// oscillator_tuning_code_stepper_top
// Three-level (coarse/mid/fine) oscillator tuning code stepper with load,
// step, and sweep commands, range clamping and sweep status.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake        | Contents
//   --------+-----------+------------------+-----------------------------------
//   cmd     | in        | valid/ready      | mode, step_amount, new_* codes
//   res     | out       | valid/ready      | codes, sweep_done, ranges_valid,
//           |           |                  | range_error
//   cfg     | in        | cfg_write strobe | cfg_index, cfg_data (6 registers)
//
// Every command transaction yields exactly one result transaction. A command
// is captured in the input register, then evaluated against the code
// registers in a single pass and written to the result register; one command
// is taken per cycle while the result channel does not stall. The code update
// (one small add/compare/clamp chain) sets this rate.
// Reset clears the codes to zero and the sweep ranges to 0..31.
// A stalled result holds its register; the input register drains into it as
// soon as it frees, so cmd.ready drops only when both stages are full.
// ----------------------------------------------------------------------------
module oscillator_tuning_code_stepper_top #(
  parameter int CODE_MAX = otcs_pkg::CODE_MAX_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  otcs_cmd_if.sink                        cmd,
  otcs_res_if.source                      res,
  input  logic                            cfg_write,
  input  logic [otcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [otcs_pkg::FIELD_W-1:0]    cfg_data
);

  import otcs_pkg::*;

  // Code register width and the signed width of intermediate arithmetic
  localparam int CW = $clog2(CODE_MAX + 1);
  localparam int SW = CW + 3;

  localparam logic signed [SW-1:0] ZERO_S = SW'(0);
  localparam logic signed [SW-1:0] ONE_S  = SW'(1);
  localparam logic signed [SW-1:0] CMAX_S = SW'(CODE_MAX);
  localparam logic signed [SW-1:0] FOV_S  = SW'(FINE_OVERLAP);
  localparam logic signed [SW-1:0] MOV_S  = SW'(MID_OVERLAP);

  // Configuration registers
  logic [FIELD_W-1:0] coarse_first, coarse_last;
  logic [FIELD_W-1:0] mid_first, mid_last;
  logic [FIELD_W-1:0] fine_first, fine_last;

  // Tuning code state
  logic [CW-1:0] coarse, mid, fine;

  // Input register
  logic               in_valid;
  logic [MODE_W-1:0]  in_mode;
  logic [STEP_W-1:0]  in_step;
  logic [FIELD_W-1:0] in_coarse, in_mid, in_fine;

  // Result register
  logic               out_valid;
  logic [FIELD_W-1:0] out_coarse, out_mid, out_fine;
  logic               out_done, out_ranges_valid, out_error;

  // Handshake
  logic out_load;
  logic in_load;

  // Single-pass results
  logic [CW-1:0] coarse_next, mid_next, fine_next;
  logic          error_next;
  logic          done_next;
  logic          ranges_valid_next;

  function automatic logic signed [SW-1:0] ext5(input logic [FIELD_W-1:0] v);
    return $signed(SW'(v));
  endfunction

  function automatic logic signed [SW-1:0] extc(input logic [CW-1:0] v);
    return $signed(SW'(v));
  endfunction

  // Clamp into 0..CODE_MAX; flag when the clamp took effect
  function automatic logic [CW:0] fit(input logic signed [SW-1:0] v);
    logic [CW:0] r;
    if (v < ZERO_S) begin
      r = {1'b1, {CW{1'b0}}};
    end else if (v > CMAX_S) begin
      r = {1'b1, CMAX_S[CW-1:0]};
    end else begin
      r = {1'b0, v[CW-1:0]};
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Flow control: the result register loads when empty or being drained; the
  // input register moves on whenever the result register takes its content.
  // --------------------------------------------------------------------------
  assign out_load  = !out_valid || res.ready;
  assign in_load   = in_valid && out_load;
  assign cmd.ready = !in_valid || out_load;

  // --------------------------------------------------------------------------
  // Configuration writes; indexes past the last register are dropped
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      coarse_first <= '0;
      coarse_last  <= '1;
      mid_first    <= '0;
      mid_last     <= '1;
      fine_first   <= '0;
      fine_last    <= '1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COARSE_FIRST: coarse_first <= cfg_data;
        REG_COARSE_LAST:  coarse_last  <= cfg_data;
        REG_MID_FIRST:    mid_first    <= cfg_data;
        REG_MID_LAST:     mid_last     <= cfg_data;
        REG_FINE_FIRST:   fine_first   <= cfg_data;
        REG_FINE_LAST:    fine_last    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register: capture a command transaction
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_mode   <= cmd.mode;
      in_step   <= cmd.step_amount;
      in_coarse <= cmd.new_coarse;
      in_mid    <= cmd.new_mid;
      in_fine   <= cmd.new_fine;
    end
  end

  // --------------------------------------------------------------------------
  // Command evaluation against the current code
  // --------------------------------------------------------------------------
  always_comb begin
    logic signed [SW-1:0] c, m, f, n;
    logic signed [SW-1:0] cf, cl, mf, ml, ff, fl;
    logic signed [SW-1:0] ctr, d, nm;
    logic [CW:0]          fc, fm, ff_fit;

    c  = extc(coarse);
    m  = extc(mid);
    f  = extc(fine);
    n  = $signed(SW'(in_step));
    cf = ext5(coarse_first);
    cl = ext5(coarse_last);
    mf = ext5(mid_first);
    ml = ext5(mid_last);
    ff = ext5(fine_first);
    fl = ext5(fine_last);
    // Midpoint of the mid range, start of a centre-out sweep
    ctr = (mf + ml) >>> 1;
    d   = ZERO_S;
    nm  = ZERO_S;

    unique case (in_mode)
      MODE_LOAD: begin
        c = ext5(in_coarse);
        m = ext5(in_mid);
        f = ext5(in_fine);
      end
      MODE_FINE_UP: begin
        if (f + n > CMAX_S) begin
          // Wrap fine into the next mid code with overlap
          f = f + FOV_S + n - CMAX_S - ONE_S;
          if (m + ONE_S > CMAX_S) begin
            m = m + MOV_S - CMAX_S;
            c = c + ONE_S;
          end else begin
            m = m + ONE_S;
          end
        end else begin
          f = f + n;
        end
      end
      MODE_FINE_DOWN: begin
        if (f < n) begin
          f = f + CMAX_S + ONE_S - FOV_S - n;
          if (m < ONE_S) begin
            m = m + CMAX_S - MOV_S;
            c = c - ONE_S;
          end else begin
            m = m - ONE_S;
          end
        end else begin
          f = f - n;
        end
      end
      MODE_MID_UP: begin
        if (m + n > CMAX_S) begin
          m = m + MOV_S + n - CMAX_S - ONE_S;
          c = c + ONE_S;
        end else begin
          m = m + n;
        end
      end
      MODE_MID_DOWN: begin
        if (m < n) begin
          m = m + CMAX_S + ONE_S - MOV_S - n;
          c = c - ONE_S;
        end else begin
          m = m - n;
        end
      end
      MODE_SWEEP_START: begin
        c = cf;
        m = (cf == cl) ? ctr : mf;
        f = ff;
      end
      MODE_SWEEP_STEP: begin
        f = f + ONE_S;
        if (f > fl) begin
          f = ff;
          if (cf == cl) begin
            // Centre-out: alternate above and below the midpoint
            d  = m - ctr;
            nm = (d <= ZERO_S) ? (ctr + ONE_S - d) : (ctr - d);
            if (nm < mf || nm > ml) begin
              nm = ctr;
            end
            m = nm;
            c = cf;
          end else begin
            m = m + ONE_S;
            if (m > ml) begin
              m = mf;
              c = c + ONE_S;
              if (c > cl) begin
                c = cf;
              end
            end
          end
        end
      end
      default: begin
        // Unused code: hold the current code
      end
    endcase

    fc     = fit(c);
    fm     = fit(m);
    ff_fit = fit(f);

    coarse_next = fc[CW-1:0];
    mid_next    = fm[CW-1:0];
    fine_next   = ff_fit[CW-1:0];
    error_next  = fc[CW] || fm[CW] || ff_fit[CW];

    done_next = (extc(coarse_next) > cl) ||
                ((extc(coarse_next) == cl) &&
                 ((extc(mid_next) > ml) ||
                  ((extc(mid_next) == ml) && (extc(fine_next) >= fl))));

    ranges_valid_next = (cf <= CMAX_S) && (cl <= CMAX_S) &&
                        (mf <= CMAX_S) && (ml <= CMAX_S) &&
                        (ff <= CMAX_S) && (fl <= CMAX_S) &&
                        (cf <= cl) && (mf <= ml) && (ff <= fl);
  end

  // --------------------------------------------------------------------------
  // Code state: advance once per command leaving the input register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      coarse <= '0;
      mid    <= '0;
      fine   <= '0;
    end else if (in_load) begin
      coarse <= coarse_next;
      mid    <= mid_next;
      fine   <= fine_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: hold while stalled
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      out_coarse       <= FIELD_W'(coarse_next);
      out_mid          <= FIELD_W'(mid_next);
      out_fine         <= FIELD_W'(fine_next);
      out_done         <= done_next;
      out_ranges_valid <= ranges_valid_next;
      out_error        <= error_next;
    end
  end

  assign res.valid        = out_valid;
  assign res.coarse_code  = out_coarse;
  assign res.mid_code     = out_mid;
  assign res.fine_code    = out_fine;
  assign res.sweep_done   = out_done;
  assign res.ranges_valid = out_ranges_valid;
  assign res.range_error  = out_error;

endmodule

/* sim/otcs_result_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// otcs_result_check
// Watches the command, result and register-write ports of the tuning code
// stepper, keeps its own copy of the code and sweep ranges, predicts the result
// of every accepted command and compares each accepted result against the
// oldest prediction.
// ----------------------------------------------------------------------------
module otcs_result_check #(
  parameter int CODE_MAX = otcs_pkg::CODE_MAX_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  otcs_cmd_if                             cmd,
  otcs_res_if                             res,
  input  logic                            cfg_write,
  input  logic [otcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [otcs_pkg::FIELD_W-1:0]    cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              result_count,
  output int                              clamp_count
);

  import otcs_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0] coarse;
    logic [FIELD_W-1:0] mid;
    logic [FIELD_W-1:0] fine;
    logic               done;
    logic               ranges_ok;
    logic               clamped;
  } code_report_t;

  // tracked code at full width; the result fields carry its low bits
  int                 coarse_q, mid_q, fine_q;
  logic [FIELD_W-1:0] coarse_lo, coarse_hi, mid_lo, mid_hi, fine_lo, fine_hi;
  code_report_t       expected_reports[$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    result_count = 0;
    clamp_count  = 0;
  end

  function automatic bit out_of_range(int v);
    return (v < 0) || (v > CODE_MAX);
  endfunction

  function automatic int clamp_code(int v);
    if (v < 0) return 0;
    if (v > CODE_MAX) return CODE_MAX;
    return v;
  endfunction

  // Apply one command to the tracked code and report the code that results.
  function automatic code_report_t advance_code(
    input logic [MODE_W-1:0]  mode,
    input logic [STEP_W-1:0]  amount,
    input logic [FIELD_W-1:0] ld_coarse,
    input logic [FIELD_W-1:0] ld_mid,
    input logic [FIELD_W-1:0] ld_fine
  );
    int c, m, f, n, mid_n, ctr, d, nm;
    int clo, chi, mlo, mhi, flo, fhi;
    bit mid_dn, mid_go;
    code_report_t r;
    c = coarse_q;  m = mid_q;  f = fine_q;  n = amount;
    clo = coarse_lo;  chi = coarse_hi;
    mlo = mid_lo;     mhi = mid_hi;
    flo = fine_lo;    fhi = fine_hi;
    mid_n  = 0;
    mid_dn = 1'b0;
    mid_go = 1'b0;
    case (mode)
      MODE_LOAD: begin
        c = ld_coarse;  m = ld_mid;  f = ld_fine;
      end
      MODE_FINE_UP: begin
        if (f + n > CODE_MAX) begin
          f += FINE_OVERLAP + n - CODE_MAX - 1;
          mid_n  = 1;
          mid_go = 1'b1;
        end else begin
          f += n;
        end
      end
      MODE_FINE_DOWN: begin
        if (f < n) begin
          f += CODE_MAX + 1 - FINE_OVERLAP - n;
          mid_n  = 1;
          mid_dn = 1'b1;
          mid_go = 1'b1;
        end else begin
          f -= n;
        end
      end
      MODE_MID_UP: begin
        mid_n  = n;
        mid_go = 1'b1;
      end
      MODE_MID_DOWN: begin
        mid_n  = n;
        mid_dn = 1'b1;
        mid_go = 1'b1;
      end
      MODE_SWEEP_START: begin
        c = clo;
        m = (clo == chi) ? (mlo + mhi) / 2 : mlo;
        f = flo;
      end
      MODE_SWEEP_STEP: begin
        f += 1;
        if (f > fhi) begin
          f = flo;
          if (clo == chi) begin
            // centre-out: alternate above and below the middle of the mid range
            ctr = (mlo + mhi) / 2;
            d   = m - ctr;
            nm  = (d <= 0) ? ctr + 1 - d : ctr - d;
            if (nm < mlo || nm > mhi) nm = ctr;
            m = nm;
            c = clo;
          end else begin
            m += 1;
            if (m > mhi) begin
              m = mlo;
              c += 1;
              if (c > chi) c = clo;
            end
          end
        end
      end
      default: ;
    endcase

    // carry a mid step into coarse with the mid overlap; zero steps are no-ops
    if (mid_go) begin
      if (mid_dn) begin
        if (m < mid_n) begin
          m += CODE_MAX + 1 - MID_OVERLAP - mid_n;
          c -= 1;
        end else begin
          m -= mid_n;
        end
      end else if (m + mid_n > CODE_MAX) begin
        m += MID_OVERLAP + mid_n - CODE_MAX - 1;
        c += 1;
      end else begin
        m += mid_n;
      end
    end

    r.clamped = out_of_range(c) || out_of_range(m) || out_of_range(f);
    coarse_q  = clamp_code(c);
    mid_q     = clamp_code(m);
    fine_q    = clamp_code(f);

    r.coarse = FIELD_W'(coarse_q);
    r.mid    = FIELD_W'(mid_q);
    r.fine   = FIELD_W'(fine_q);
    r.done   = (coarse_q > coarse_hi) ||
               (coarse_q == coarse_hi &&
                (mid_q > mid_hi || (mid_q == mid_hi && fine_q >= fine_hi)));
    r.ranges_ok = (coarse_lo <= CODE_MAX) && (coarse_hi <= CODE_MAX) &&
                  (mid_lo <= CODE_MAX) && (mid_hi <= CODE_MAX) &&
                  (fine_lo <= CODE_MAX) && (fine_hi <= CODE_MAX) &&
                  (coarse_lo <= coarse_hi) && (mid_lo <= mid_hi) &&
                  (fine_lo <= fine_hi);
    return r;
  endfunction

  always @(posedge clk) begin
    code_report_t got, want;
    if (rst) begin
      coarse_q  = 0;  mid_q  = 0;  fine_q  = 0;
      coarse_lo = '0;  mid_lo = '0;  fine_lo = '0;
      coarse_hi = 5'd31;  mid_hi = 5'd31;  fine_hi = 5'd31;
      expected_reports.delete();
    end else begin
      // compare first: a result never stems from a command taken at the same edge
      if (res.valid && res.ready) begin
        result_count++;
        got = {res.coarse_code, res.mid_code, res.fine_code,
               res.sweep_done, res.ranges_valid, res.range_error};
        if (expected_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with no command outstanding: c=%0d m=%0d f=%0d",
                     $realtime, got.coarse, got.mid, got.fine);
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected c=%0d m=%0d f=%0d done=%b ranges_valid=%b err=%b",
                       want.coarse, want.mid, want.fine, want.done,
                       want.ranges_ok, want.clamped);
              $display("  actual   c=%0d m=%0d f=%0d done=%b ranges_valid=%b err=%b",
                       got.coarse, got.mid, got.fine, got.done,
                       got.ranges_ok, got.clamped);
            end
          end
        end
      end

      if (cfg_write) begin
        case (cfg_index)
          REG_COARSE_FIRST: coarse_lo = cfg_data;
          REG_COARSE_LAST:  coarse_hi = cfg_data;
          REG_MID_FIRST:    mid_lo    = cfg_data;
          REG_MID_LAST:     mid_hi    = cfg_data;
          REG_FINE_FIRST:   fine_lo   = cfg_data;
          REG_FINE_LAST:    fine_hi   = cfg_data;
          default: ;
        endcase
      end

      if (cmd.valid && cmd.ready) begin
        want = advance_code(cmd.mode, cmd.step_amount, cmd.new_coarse,
                            cmd.new_mid, cmd.new_fine);
        if (want.clamped) clamp_count++;
        expected_reports.push_back(want);
      end
    end
    pending = expected_reports.size();
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the oscillator tuning code stepper: a short directed
// pass over wraps, clamps and every command, then randomized command streams
// dominated by sweep runs under a series of sweep-range settings, with random
// stalls on both channels. Result checking lives in otcs_result_check.
// ----------------------------------------------------------------------------
module testbench;
  import otcs_pkg::*;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int ITEMS_PER_PHASE = 90;
  localparam int NUM_PHASES      = 12;
  localparam int SIDE_CMD        = 0;
  localparam int SIDE_RES        = 1;

  // mode 7 is not decoded by the block; it must leave the code alone
  localparam logic [MODE_W-1:0] MODE_RESERVED = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [FIELD_W-1:0]    cfg_data  = '0;

  int fail_count, pending, result_count, clamp_count;
  int sent_count     = 0;
  int sweep_steps    = 0;
  int settings_count = 0;
  int idle_cycles    = 0;
  int burst_left[2]  = '{0, 0};

  otcs_cmd_if cmd_ch ();
  otcs_res_if res_ch ();

  always #HALF_PERIOD clk = ~clk;

  oscillator_tuning_code_stepper_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .res       (res_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  otcs_result_check i_check (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd_ch),
    .res          (res_ch),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count),
    .clamp_count  (clamp_count)
  );

  // Draw the idle cycles ahead of the next transaction on one side. Now and
  // then open a burst with no idling so back-to-back traffic is covered too.
  function automatic int draw_gap(int side);
    if (burst_left[side] > 0) begin
      burst_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  // Offer one command at a falling edge and hold it until it is taken.
  // Call at a falling edge; returns at the falling edge after the transaction.
  task automatic send_cmd(
    input logic [MODE_W-1:0]  mode,
    input logic [STEP_W-1:0]  amount,
    input logic [FIELD_W-1:0] ld_coarse,
    input logic [FIELD_W-1:0] ld_mid,
    input logic [FIELD_W-1:0] ld_fine
  );
    int gap;
    gap = draw_gap(SIDE_CMD);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.mode        <= mode;
    cmd_ch.step_amount <= amount;
    cmd_ch.new_coarse  <= ld_coarse;
    cmd_ch.new_mid     <= ld_mid;
    cmd_ch.new_fine    <= ld_fine;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    @(negedge clk);
    sent_count++;
    if (mode == MODE_SWEEP_STEP) sweep_steps++;
  endtask

  // Send one command of random kind; unused fields carry random noise.
  task automatic send_random_cmd();
    int pick;
    logic [MODE_W-1:0] mode;
    pick = $urandom_range(0, 99);
    if (pick < 15)      mode = MODE_LOAD;
    else if (pick < 30) mode = MODE_FINE_UP;
    else if (pick < 45) mode = MODE_FINE_DOWN;
    else if (pick < 57) mode = MODE_MID_UP;
    else if (pick < 69) mode = MODE_MID_DOWN;
    else if (pick < 75) mode = MODE_SWEEP_START;
    else if (pick < 95) mode = MODE_SWEEP_STEP;
    else                mode = MODE_RESERVED;
    send_cmd(mode, STEP_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
             FIELD_W'($urandom));
  endtask

  // Drop valid and hold until every command has produced its result, then let
  // the two-stage pipeline settle before anything touches the registers.
  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One register write per cycle; keep the strobe high across the six writes.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [FIELD_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
  endtask

  task automatic configure(
    input logic [FIELD_W-1:0] c_first, c_last,
    input logic [FIELD_W-1:0] m_first, m_last,
    input logic [FIELD_W-1:0] f_first, f_last
  );
    write_reg(REG_COARSE_FIRST, c_first);
    write_reg(REG_COARSE_LAST,  c_last);
    write_reg(REG_MID_FIRST,    m_first);
    write_reg(REG_MID_LAST,     m_last);
    write_reg(REG_FINE_FIRST,   f_first);
    write_reg(REG_FINE_LAST,    f_last);
    cfg_write <= 1'b0;
    @(negedge clk);
    settings_count++;
  endtask

  // Random sweep ranges: mostly narrow so sweeps roll over into mid and
  // coarse quickly, a third of them single-coarse (centre-out), and a few
  // with a reversed pair so ranges_valid drops.
  task automatic configure_random();
    logic [FIELD_W-1:0] lo[3], hi[3], t;
    int k, span;
    for (k = 0; k < 3; k++) begin
      lo[k] = FIELD_W'($urandom_range(0, 31));
      span  = (k == 0 && $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
      hi[k] = (lo[k] + span > 31) ? 5'd31 : FIELD_W'(lo[k] + span);
    end
    if ($urandom_range(0, 7) == 0) begin
      k = $urandom_range(0, 2);
      t = lo[k];  lo[k] = hi[k];  hi[k] = t;
    end
    configure(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
  endtask

  // Result side: ready idles at random ahead of each result transaction.
  initial begin : result_sink
    int gap;
    res_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = draw_gap(SIDE_RES);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int phase, phase_items, run_len, k;
    cmd_ch.valid       = 1'b0;
    cmd_ch.mode        = MODE_LOAD;
    cmd_ch.step_amount = '0;
    cmd_ch.new_coarse  = '0;
    cmd_ch.new_mid     = '0;
    cmd_ch.new_fine    = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed pass under the reset ranges (0..31 on every level, linear sweep).
    // Top corner: sweep done, then a fine wrap that carries through mid into a
    // coarse overflow and gets clamped.
    send_cmd(MODE_LOAD, 4'd0, 5'd31, 5'd31, 5'd31);
    send_cmd(MODE_FINE_UP, 4'd15, 5'd0, 5'd0, 5'd0);
    // Bottom corner: fine wrap down borrows from mid and underflows coarse.
    send_cmd(MODE_LOAD, 4'd0, 5'd0, 5'd0, 5'd0);
    send_cmd(MODE_FINE_DOWN, 4'd15, 5'd31, 5'd31, 5'd31);
    // Zero-length steps leave the code untouched.
    send_cmd(MODE_LOAD, 4'd15, 5'd12, 5'd31, 5'd30);
    send_cmd(MODE_FINE_UP, 4'd0, 5'd0, 5'd0, 5'd0);
    send_cmd(MODE_FINE_DOWN, 4'd0, 5'd0, 5'd0, 5'd0);
    send_cmd(MODE_MID_UP, 4'd0, 5'd0, 5'd0, 5'd0);
    send_cmd(MODE_MID_DOWN, 4'd0, 5'd0, 5'd0, 5'd0);
    // Channel hop and RX/TX offset, then the largest mid steps both ways.
    send_cmd(MODE_MID_UP, 4'(MID_PER_CHANNEL), 5'd0, 5'd0, 5'd0);
    send_cmd(MODE_MID_DOWN, 4'(MID_RX_TX), 5'd0, 5'd0, 5'd0);
    send_cmd(MODE_MID_UP, 4'd15, 5'd0, 5'd0, 5'd0);
    send_cmd(MODE_MID_DOWN, 4'd15, 5'd0, 5'd0, 5'd0);
    send_cmd(MODE_LOAD, 4'd0, 5'd0, 5'd5, 5'd0);
    send_cmd(MODE_MID_DOWN, 4'd15, 5'd0, 5'd0, 5'd0);
    // Sweep start and steps, including fine and coarse rollover.
    send_cmd(MODE_SWEEP_START, 4'd15, 5'd31, 5'd31, 5'd31);
    send_cmd(MODE_SWEEP_STEP, 4'd0, 5'd0, 5'd0, 5'd0);
    send_cmd(MODE_LOAD, 4'd0, 5'd0, 5'd0, 5'd31);
    send_cmd(MODE_SWEEP_STEP, 4'd0, 5'd0, 5'd0, 5'd0);
    send_cmd(MODE_LOAD, 4'd0, 5'd31, 5'd31, 5'd31);
    send_cmd(MODE_SWEEP_STEP, 4'd0, 5'd0, 5'd0, 5'd0);
    // Undecoded mode with every field at all ones.
    send_cmd(MODE_RESERVED, 4'd15, 5'd31, 5'd31, 5'd31);
    wait_idle();

    // Random phases: fixed corner settings first, then random ranges.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: configure(5'd7, 5'd7, 5'd0, 5'd31, 5'd0, 5'd3);        // centre-out, full mid
        1: configure(5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31);   // all at the top
        2: configure(5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0);         // all at the bottom
        3: configure(5'd20, 5'd3, 5'd25, 5'd2, 5'd17, 5'd4);      // every range reversed
        4: configure(5'd2, 5'd4, 5'd10, 5'd13, 5'd28, 5'd31);     // short linear sweep
        5: configure(5'd0, 5'd31, 5'd0, 5'd31, 5'd0, 5'd31);      // back to reset ranges
        default: configure_random();
      endcase
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) < 5) begin
          // well-formed sweep: start, then a run of steps, often long enough to roll
          // fine over into mid, and at times mid into coarse
          run_len = $urandom_range(4, 30);
          send_cmd(MODE_SWEEP_START, STEP_W'($urandom), FIELD_W'($urandom),
                   FIELD_W'($urandom), FIELD_W'($urandom));
          for (k = 0; k < run_len; k++)
            send_cmd(MODE_SWEEP_STEP, STEP_W'($urandom), FIELD_W'($urandom),
                     FIELD_W'($urandom), FIELD_W'($urandom));
          phase_items += run_len + 1;
        end else begin
          send_random_cmd();
          phase_items++;
        end
      end
      wait_idle();
    end

    // Drain: nothing outstanding, then allow for any stray late result.
    wait_idle();
    repeat (8) @(negedge clk);

    $display("Sent %0d commands (%0d sweep steps) across %0d range settings;",
             sent_count, sweep_steps, settings_count);
    $display("checked %0d results, %0d of them with a clamped code.",
             result_count, clamp_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
